/* src/assert_macros.svh */
// Assertion macros used by the checker file of the parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("resp parser assertion failed");

// Clocked property, checked during reset as well.
`define ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("resp parser reset assertion failed");

`endif

/* src/resp_pkg.sv */
// Shared types and constants of the RESP command parser.
`timescale 1ns / 1ps

package resp_pkg;

  localparam int MAX_EL_W   = 16;
  localparam int MAX_LEN_W  = 30;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ELEMENTS    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BULK_LENGTH = 8'd1;

  localparam logic [MAX_EL_W-1:0]  MAX_EL_RESET  = 16'd1024;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 30'd536870912;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [1:0] {
    EV_BYTE  = 2'd0,
    EV_END   = 2'd1,
    EV_ERR   = 2'd2,
    EV_EMPTY = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NOT_STAR  = 3'd1,
    ERR_NOT_DOLL  = 3'd2,
    ERR_BAD_DIGIT = 3'd3,
    ERR_OVER      = 3'd4
  } err_e;

  typedef enum logic [8:0] {
    PH_IDLE     = 9'b000000001,
    PH_COUNT    = 9'b000000010,
    PH_COUNT_LF = 9'b000000100,
    PH_MARK     = 9'b000001000,
    PH_LEN      = 9'b000010000,
    PH_LEN_LF   = 9'b000100000,
    PH_DATA     = 9'b001000000,
    PH_TRAIL1   = 9'b010000000,
    PH_TRAIL2   = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic [MAX_EL_W-1:0]  max_elements;
    logic [MAX_LEN_W-1:0] max_bulk_length;
  } cfg_t;

  typedef struct packed {
    event_e     ev;
    logic [7:0] payload;
    logic       last;
    err_e       err;
  } res_t;

endpackage

/* src/resp_cfg_regs.sv */
// Configuration registers of the RESP command parser.
`timescale 1ns / 1ps

module resp_cfg_regs
  import resp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAX_ELEMENTS:    cfg_d.max_elements    = cfg_data_i[MAX_EL_W-1:0];
        CFG_MAX_BULK_LENGTH: cfg_d.max_bulk_length = cfg_data_i[MAX_LEN_W-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_elements    <= MAX_EL_RESET;
      cfg_q.max_bulk_length <= MAX_LEN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* src/resp_parse_core.sv */
// Parse state and per-byte decode of the RESP command parser.
`timescale 1ns / 1ps

module resp_parse_core
  import resp_pkg::*;
#(
  parameter int COUNT_BITS  = 16,
  parameter int LENGTH_BITS = 30
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   flush_i,
  input  cfg_t                   cfg_i,
  output logic                   res_fire_o,
  output res_t                   res_o,
  output logic [COUNT_BITS-1:0]  res_index_o,
  output logic [LENGTH_BITS-1:0] res_length_o
);

  localparam int ACC_W = (COUNT_BITS > LENGTH_BITS) ? COUNT_BITS : LENGTH_BITS;
  localparam int W     = (ACC_W + 4 > MAX_LEN_W + 1) ? ACC_W + 4 : MAX_LEN_W + 1;

  localparam logic [W-1:0] COUNT_MAX = {{(W-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};
  localparam logic [W-1:0] LEN_MAX   = {{(W-LENGTH_BITS){1'b0}}, {LENGTH_BITS{1'b1}}};

  phase_e                 phase_q, phase_d;
  logic [COUNT_BITS-1:0]  total_q, total_d;
  logic [COUNT_BITS-1:0]  num_q, num_d;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic                   seen_q, seen_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;

  logic [W-1:0] acc_ext, acc_next, el_ext, bl_ext, count_cap, length_cap, cap;
  logic         is_cr, is_digit, over, is_last, clear, fail;
  err_e         fail_code;

  // Digit step: acc * 10 + digit, wide enough to never wrap.
  assign acc_ext  = {{(W-ACC_W){1'b0}}, acc_q};
  assign acc_next = (acc_ext << 3) + (acc_ext << 1) + {{(W-4){1'b0}}, data_byte_i[3:0]};
  assign el_ext   = {{(W-MAX_EL_W){1'b0}}, cfg_i.max_elements};
  assign bl_ext   = {{(W-MAX_LEN_W){1'b0}}, cfg_i.max_bulk_length};
  assign count_cap  = (el_ext < COUNT_MAX) ? el_ext : COUNT_MAX;
  assign length_cap = (bl_ext < LEN_MAX) ? bl_ext : LEN_MAX;
  assign cap        = (phase_q == PH_COUNT) ? count_cap : length_cap;
  assign over       = acc_next > cap;
  assign is_cr      = data_byte_i == CH_CR;
  assign is_digit   = (data_byte_i >= CH_ZERO) && (data_byte_i <= CH_NINE);
  assign is_last    = ({1'b0, num_q} + {{COUNT_BITS{1'b0}}, 1'b1}) >= {1'b0, total_q};

  always_comb begin
    phase_d      = phase_q;
    total_d      = total_q;
    num_d        = num_q;
    acc_d        = acc_q;
    seen_d       = seen_q;
    rem_d        = rem_q;
    len_d        = len_q;
    clear        = 1'b0;
    fail         = 1'b0;
    fail_code    = ERR_NONE;
    res_fire_o   = 1'b0;
    res_o        = '{ev: EV_BYTE, payload: 8'd0, last: 1'b0, err: ERR_NONE};
    res_index_o  = '0;
    res_length_o = '0;

    if (accept_i) begin
      if (flush_i) begin
        clear = 1'b1;
      end else begin
        case (phase_q)
          PH_IDLE: begin
            if (data_byte_i != CH_STAR) begin
              fail      = 1'b1;
              fail_code = ERR_NOT_STAR;
            end else begin
              acc_d   = '0;
              seen_d  = 1'b0;
              phase_d = PH_COUNT;
            end
          end
          PH_COUNT, PH_LEN: begin
            if (is_cr) begin
              if (seen_q) begin
                phase_d = (phase_q == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
              end else begin
                fail      = 1'b1;
                fail_code = ERR_BAD_DIGIT;
              end
            end else if (!is_digit) begin
              fail      = 1'b1;
              fail_code = ERR_BAD_DIGIT;
            end else begin
              acc_d  = acc_next[ACC_W-1:0];
              seen_d = 1'b1;
              if (over) begin
                fail      = 1'b1;
                fail_code = ERR_OVER;
              end
            end
          end
          PH_COUNT_LF: begin
            if (data_byte_i != CH_LF) begin
              fail      = 1'b1;
              fail_code = ERR_BAD_DIGIT;
            end else if (acc_q == '0) begin
              clear      = 1'b1;
              res_fire_o = 1'b1;
              res_o.ev   = EV_EMPTY;
            end else begin
              total_d = acc_q[COUNT_BITS-1:0];
              num_d   = '0;
              phase_d = PH_MARK;
            end
          end
          PH_MARK: begin
            if (data_byte_i != CH_DOLLAR) begin
              fail      = 1'b1;
              fail_code = ERR_NOT_DOLL;
            end else begin
              acc_d   = '0;
              seen_d  = 1'b0;
              phase_d = PH_LEN;
            end
          end
          PH_LEN_LF: begin
            if (data_byte_i != CH_LF) begin
              fail      = 1'b1;
              fail_code = ERR_BAD_DIGIT;
            end else begin
              len_d   = acc_q[LENGTH_BITS-1:0];
              rem_d   = acc_q[LENGTH_BITS-1:0];
              phase_d = (acc_q[LENGTH_BITS-1:0] != '0) ? PH_DATA : PH_TRAIL1;
            end
          end
          PH_DATA: begin
            rem_d = rem_q - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
            if (rem_q == {{(LENGTH_BITS-1){1'b0}}, 1'b1}) begin
              phase_d = PH_TRAIL1;
            end
            res_fire_o    = 1'b1;
            res_o.payload = data_byte_i;
            res_index_o   = num_q;
            res_length_o  = len_q;
          end
          PH_TRAIL1: begin
            phase_d = PH_TRAIL2;
          end
          PH_TRAIL2: begin
            res_fire_o   = 1'b1;
            res_o.ev     = EV_END;
            res_o.last   = is_last;
            res_index_o  = num_q;
            res_length_o = len_q;
            if (is_last) begin
              clear = 1'b1;
            end else begin
              num_d   = num_q + {{(COUNT_BITS-1){1'b0}}, 1'b1};
              phase_d = PH_MARK;
            end
          end
          default: begin
            clear = 1'b1;
          end
        endcase
      end
    end

    // Report the error with the element number held before the drop.
    if (fail) begin
      res_fire_o  = 1'b1;
      res_o.ev    = EV_ERR;
      res_o.err   = fail_code;
      res_index_o = num_q;
      clear       = 1'b1;
    end

    if (clear) begin
      phase_d = PH_IDLE;
      total_d = '0;
      num_d   = '0;
      acc_d   = '0;
      seen_d  = 1'b0;
      rem_d   = '0;
      len_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      total_q <= '0;
      num_q   <= '0;
      acc_q   <= '0;
      seen_q  <= 1'b0;
      rem_q   <= '0;
      len_q   <= '0;
    end else begin
      phase_q <= phase_d;
      total_q <= total_d;
      num_q   <= num_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
      rem_q   <= rem_d;
      len_q   <= len_d;
    end
  end

endmodule

/* src/resp_out_reg.sv */
// Result register of the RESP command parser.
`timescale 1ns / 1ps

module resp_out_reg
  import resp_pkg::*;
#(
  parameter int COUNT_BITS  = 16,
  parameter int LENGTH_BITS = 30
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   res_fire_i,
  input  res_t                   res_i,
  input  logic [COUNT_BITS-1:0]  res_index_i,
  input  logic [LENGTH_BITS-1:0] res_length_i,
  output logic                   can_take_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output res_t                   res_o,
  output logic [COUNT_BITS-1:0]  res_index_o,
  output logic [LENGTH_BITS-1:0] res_length_o
);

  logic                   valid_q, valid_d;
  res_t                   res_q;
  logic [COUNT_BITS-1:0]  index_q;
  logic [LENGTH_BITS-1:0] length_q;

  // Room for a new result when none is held or the held one leaves in this cycle.
  assign can_take_o   = !valid_q || out_ready_i;
  assign out_valid_o  = valid_q;
  assign res_o        = res_q;
  assign res_index_o  = index_q;
  assign res_length_o = length_q;

  always_comb begin
    valid_d = valid_q;
    if (res_fire_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire_i) begin
      res_q    <= res_i;
      index_q  <= res_index_i;
      length_q <= res_length_i;
    end
  end

endmodule

/* src/resp_command_parser.sv */
// Top level of the RESP command parser: array of bulk strings, one byte per item.
// A result is registered and appears on the output in the cycle after the item that causes it.
// Throughput: one byte item per cycle while in_ready_o is high; the parse state register updates every cycle.
// The output register holds a result until the consumer takes it; no byte is taken while it stalls.
// Reset: asynchronous, active low; parser idle, limits 1024 elements and 2^29 bytes.
`timescale 1ns / 1ps

module resp_command_parser
  import resp_pkg::*;
#(
  parameter int COUNT_BITS  = 16,
  parameter int LENGTH_BITS = 30
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // byte input channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   flush_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             event_res_o,
  output logic [7:0]             payload_o,
  output logic [COUNT_BITS-1:0]  element_index_o,
  output logic [LENGTH_BITS-1:0] element_length_o,
  output logic                   last_element_o,
  output logic [2:0]             error_code_o
);

  cfg_t                   cfg;
  logic                   accept;
  logic                   res_fire;
  res_t                   res_next, res_held;
  logic [COUNT_BITS-1:0]  index_next;
  logic [LENGTH_BITS-1:0] length_next;

  // Limits for the count and length headers.
  resp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Take a byte whenever the result register can absorb what it may cause.
  assign accept = in_valid_i && in_ready_o;

  // Decode the byte against the parse state and advance it.
  resp_parse_core #(
    .COUNT_BITS  (COUNT_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .flush_i      (flush_i),
    .cfg_i        (cfg),
    .res_fire_o   (res_fire),
    .res_o        (res_next),
    .res_index_o  (index_next),
    .res_length_o (length_next)
  );

  // Hold the result until the consumer takes it.
  resp_out_reg #(
    .COUNT_BITS  (COUNT_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_fire_i   (res_fire),
    .res_i        (res_next),
    .res_index_i  (index_next),
    .res_length_i (length_next),
    .can_take_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res_held),
    .res_index_o  (element_index_o),
    .res_length_o (element_length_o)
  );

  assign event_res_o    = res_held.ev;
  assign payload_o      = res_held.payload;
  assign last_element_o = res_held.last;
  assign error_code_o   = res_held.err;

endmodule

/* src/resp_checker.sv */
// Port-level assertions of the RESP command parser and their bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module resp_checker
  import resp_pkg::*;
#(
  parameter int COUNT_BITS  = 16,
  parameter int LENGTH_BITS = 30
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [1:0]             event_res_o,
  input logic [7:0]             payload_o,
  input logic [COUNT_BITS-1:0]  element_index_o,
  input logic [LENGTH_BITS-1:0] element_length_o,
  input logic                   last_element_o,
  input logic [2:0]             error_code_o
);

  logic [COUNT_BITS+LENGTH_BITS+13:0] out_bundle;

  assign out_bundle = {event_res_o, payload_o, element_index_o, element_length_o,
                       last_element_o, error_code_o};

  `ASSERT_RST(a_no_result_in_reset, !rst_ni |-> !out_valid_o)
  `ASSERT_CLK(a_stall_holds, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_bundle))
  `ASSERT_CLK(a_payload_only_bytes, out_valid_o && event_res_o != EV_BYTE |-> payload_o == 8'd0)
  `ASSERT_CLK(a_err_code_matches, out_valid_o |-> ((event_res_o == EV_ERR) == (error_code_o != ERR_NONE)))
  `ASSERT_CLK(a_last_on_end, out_valid_o && last_element_o |-> event_res_o == EV_END)

endmodule

bind resp_command_parser resp_checker #(
  .COUNT_BITS  (COUNT_BITS),
  .LENGTH_BITS (LENGTH_BITS)
) u_resp_checker (.*);
